// ===== rtl/core/ndrs_pkg.sv =====
// Package for the nozzle dose round sequencer.
// Holds the item, result and configuration types, the codes and the phase type.
// No dependencies; the stages, the core, the top level and the test files import it.
package ndrs_pkg;

    // Width of the enable mask register as the register map defines it.
    localparam int MASK_W = 18;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    // Input item kinds.
    localparam logic [1:0] KIND_POLL = 2'd0;
    localparam logic [1:0] KIND_RATE = 2'd1;
    localparam logic [1:0] KIND_CTRL = 2'd2;

    // Control commands.
    localparam logic CMD_RESTART = 1'b0;
    localparam logic CMD_STOP    = 1'b1;

    // Result actions.
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_MOVE       = 3'd1;
    localparam logic [2:0] ACT_PARK       = 3'd2;
    localparam logic [2:0] ACT_PUMP       = 3'd3;
    localparam logic [2:0] ACT_STOP       = 3'd4;
    localparam logic [2:0] ACT_STOP_RHOME = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ENABLED_MASK = 2'd0;
    localparam logic [1:0] CFG_SLICES       = 2'd1;
    localparam logic [1:0] CFG_ACCESS_MS    = 2'd2;

    // Phase codes as they appear on the result.
    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_WAIT_MOTOR  = 3'd1;
    localparam logic [2:0] PH_HOMING      = 3'd2;
    localparam logic [2:0] PH_PICK        = 3'd3;
    localparam logic [2:0] PH_WAIT_MOVE   = 3'd4;
    localparam logic [2:0] PH_WAIT_PUMP   = 3'd5;
    localparam logic [2:0] PH_WAIT_LAST   = 3'd6;
    localparam logic [2:0] PH_WAIT_ACCESS = 3'd7;

    // Sequencer state, one-hot.
    typedef enum logic [7:0] {
        ST_IDLE        = 8'b0000_0001,
        ST_WAIT_MOTOR  = 8'b0000_0010,
        ST_HOMING      = 8'b0000_0100,
        ST_PICK        = 8'b0000_1000,
        ST_WAIT_MOVE   = 8'b0001_0000,
        ST_WAIT_PUMP   = 8'b0010_0000,
        ST_WAIT_LAST   = 8'b0100_0000,
        ST_WAIT_ACCESS = 8'b1000_0000
    } phase_t;

    // One input item.
    typedef struct packed {
        logic [1:0]  kind;
        logic        command;
        logic        stepper_idle;
        logic        at_origin;
        logic        homing_done;
        logic        pump_idle;
        logic        ms_tick;
        logic        parked_at_last;
        logic [4:0]  rate_nozzle;
        logic [11:0] whole_ticks;
        logic [15:0] tick_fraction;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [2:0]  action;
        logic [4:0]  target_nozzle;
        logic [12:0] pump_ticks;
        logic [2:0]  phase;
        logic [15:0] round_index;
    } result_t;

    // Configuration write as it travels to the core.
    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_write_t;

    // Map the one-hot state to its result code.
    function automatic logic [2:0] phase_code(input phase_t st);
        logic [2:0] code;
        unique case (st)
            ST_IDLE:        code = PH_IDLE;
            ST_WAIT_MOTOR:  code = PH_WAIT_MOTOR;
            ST_HOMING:      code = PH_HOMING;
            ST_PICK:        code = PH_PICK;
            ST_WAIT_MOVE:   code = PH_WAIT_MOVE;
            ST_WAIT_PUMP:   code = PH_WAIT_PUMP;
            ST_WAIT_LAST:   code = PH_WAIT_LAST;
            ST_WAIT_ACCESS: code = PH_WAIT_ACCESS;
            default:        code = PH_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/ndrs_in_if.sv =====
// Input channel of the nozzle dose round sequencer: valid, ready and item fields.
// No dependencies.
interface ndrs_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        command;
    logic        stepper_idle;
    logic        at_origin;
    logic        homing_done;
    logic        pump_idle;
    logic        ms_tick;
    logic        parked_at_last;
    logic [4:0]  rate_nozzle;
    logic [11:0] whole_ticks;
    logic [15:0] tick_fraction;

    modport source (
        output valid, kind, command, stepper_idle, at_origin, homing_done,
               pump_idle, ms_tick, parked_at_last, rate_nozzle, whole_ticks,
               tick_fraction,
        input  ready
    );

    modport sink (
        input  valid, kind, command, stepper_idle, at_origin, homing_done,
               pump_idle, ms_tick, parked_at_last, rate_nozzle, whole_ticks,
               tick_fraction,
        output ready
    );
endinterface

// ===== rtl/core/ndrs_out_if.sv =====
// Result channel of the nozzle dose round sequencer: valid, ready and result fields.
// No dependencies.
interface ndrs_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [4:0]  target_nozzle;
    logic [12:0] pump_ticks;
    logic [2:0]  phase;
    logic [15:0] round_index;

    modport source (
        output valid, action, target_nozzle, pump_ticks, phase, round_index,
        input  ready
    );

    modport sink (
        input  valid, action, target_nozzle, pump_ticks, phase, round_index,
        output ready
    );
endinterface

// ===== rtl/core/ndrs_in_stage.sv =====
// Input register of the sequencer: captures one request from the input channel.
// Depends on ndrs_pkg and ndrs_in_if.
module ndrs_in_stage
    import ndrs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ndrs_in_if.sink   items,
    input  logic      advance,
    output logic      item_valid,
    output item_t     item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  take;

    // A new request enters when the register is empty or moves on this cycle.
    assign items.ready = !valid_reg || advance;
    assign take        = items.valid && items.ready;
    assign valid_next  = take || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds no reset.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind           <= items.kind;
            item_reg.command        <= items.command;
            item_reg.stepper_idle   <= items.stepper_idle;
            item_reg.at_origin      <= items.at_origin;
            item_reg.homing_done    <= items.homing_done;
            item_reg.pump_idle      <= items.pump_idle;
            item_reg.ms_tick        <= items.ms_tick;
            item_reg.parked_at_last <= items.parked_at_last;
            item_reg.rate_nozzle    <= items.rate_nozzle;
            item_reg.whole_ticks    <= items.whole_ticks;
            item_reg.tick_fraction  <= items.tick_fraction;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/ndrs_core.sv =====
// Sequencer core: configuration, phase state, rate tables and residue accumulators.
// Processes one request per cycle when fire is high. Depends on ndrs_pkg.
module ndrs_core
    import ndrs_pkg::*;
#(
    parameter int NOZZLES = 18
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    input  logic       fire,
    input  item_t      item,
    output result_t    result
);

    localparam int CUR_W = $clog2(NOZZLES + 1);
    localparam int IDX_W = (NOZZLES > 1) ? $clog2(NOZZLES) : 1;

    // Configuration registers.
    logic [MASK_W-1:0] mask_reg;
    logic [15:0]       slices_reg;
    logic [31:0]       access_reg;

    // Sequencer state.
    phase_t            phase_reg, phase_next;
    logic [CUR_W-1:0]  cur_reg, cur_next;
    logic [31:0]       elapsed_reg, elapsed_next;
    logic [15:0]       round_reg, round_next;

    // Per-nozzle storage.
    logic [11:0]       rate_whole_reg [NOZZLES];
    logic [15:0]       rate_frac_reg  [NOZZLES];
    logic [15:0]       residue_reg    [NOZZLES];

    logic [31:0]       mask_wide;
    logic [NOZZLES-1:0] on_vec;
    logic [CUR_W-1:0]  found_idx;
    logic              found;
    logic              cur_valid;
    logic [IDX_W-1:0]  cur_idx;
    logic [16:0]       frac_sum;
    logic [15:0]       new_residue;
    logic              last_slice;
    logic [12:0]       dose_ticks;
    logic [31:0]       elapsed_inc;
    logic [15:0]       round_inc;
    logic              res_we;
    logic              res_clear;
    logic              rate_we;
    logic [IDX_W-1:0]  rate_idx;
    logic [2:0]        act;
    logic [4:0]        tgt;
    logic [12:0]       ticks;

    // Enabled nozzles, limited to the mask width.
    assign mask_wide = 32'(mask_reg);

    always_comb
    begin
        for (int i = 0; i < NOZZLES; i++)
        begin
            on_vec[i] = mask_wide[i];
        end
    end

    // Lowest enabled nozzle at or above the current one.
    always_comb
    begin
        found_idx = CUR_W'(NOZZLES);
        found     = 1'b0;
        for (int i = NOZZLES - 1; i >= 0; i--)
        begin
            if (on_vec[i] && (CUR_W'(i) >= cur_reg))
            begin
                found_idx = CUR_W'(i);
                found     = 1'b1;
            end
        end
    end

    // Dose for the current nozzle: whole ticks, residue carry, last-slice tick.
    assign cur_valid   = (cur_reg < CUR_W'(NOZZLES));
    assign cur_idx     = cur_reg[IDX_W-1:0];
    assign frac_sum    = {1'b0, residue_reg[cur_idx]} + {1'b0, rate_frac_reg[cur_idx]};
    assign new_residue = frac_sum[15:0];
    assign last_slice  = (slices_reg != 16'd0) && (round_reg == slices_reg - 16'd1);
    assign dose_ticks  = {1'b0, rate_whole_reg[cur_idx]} + {12'd0, frac_sum[16]}
                       + {12'd0, last_slice && (new_residue != 16'd0)};

    assign elapsed_inc = elapsed_reg + {31'd0, item.ms_tick};
    assign round_inc   = round_reg + 16'd1;

    // Rate writes go to an in-range nozzle only.
    assign rate_we  = fire && (item.kind == KIND_RATE)
                    && ({1'b0, item.rate_nozzle} < 6'(NOZZLES));
    assign rate_idx = item.rate_nozzle[IDX_W-1:0];

    // Next-state and result logic for one request.
    always_comb
    begin
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        elapsed_next = elapsed_reg;
        round_next   = round_reg;
        act          = ACT_NONE;
        tgt          = 5'd0;
        ticks        = 13'd0;
        res_we       = 1'b0;
        res_clear    = 1'b0;
        if (fire)
        begin
            unique case (item.kind)
                KIND_CTRL:
                begin
                    if (item.command == CMD_RESTART)
                    begin
                        phase_next = ST_WAIT_MOTOR;
                        round_next = 16'd0;
                        res_clear  = 1'b1;
                        act        = ACT_STOP_RHOME;
                    end
                    else
                    begin
                        phase_next = ST_IDLE;
                        act        = ACT_STOP;
                    end
                end
                KIND_POLL:
                begin
                    if (!(phase_reg == ST_IDLE || phase_reg == ST_WAIT_MOTOR
                          || phase_reg == ST_HOMING))
                    begin
                        elapsed_next = elapsed_inc;
                    end
                    unique case (phase_reg)
                        ST_IDLE:
                        begin
                        end
                        ST_WAIT_MOTOR:
                        begin
                            if (item.stepper_idle)
                            begin
                                cur_next   = '0;
                                phase_next = item.at_origin ? ST_PICK : ST_HOMING;
                            end
                        end
                        ST_HOMING:
                        begin
                            if (item.homing_done)
                            begin
                                phase_next = ST_PICK;
                            end
                        end
                        ST_PICK:
                        begin
                            cur_next = found_idx;
                            if (found)
                            begin
                                act        = ACT_MOVE;
                                tgt        = 5'(found_idx);
                                phase_next = ST_WAIT_MOVE;
                            end
                            else if (item.parked_at_last)
                            begin
                                act        = ACT_PARK;
                                phase_next = ST_WAIT_ACCESS;
                            end
                            else
                            begin
                                act        = ACT_MOVE;
                                tgt        = 5'(NOZZLES - 1);
                                phase_next = ST_WAIT_LAST;
                            end
                        end
                        ST_WAIT_MOVE:
                        begin
                            if (item.stepper_idle)
                            begin
                                if (cur_valid)
                                begin
                                    ticks  = dose_ticks;
                                    res_we = 1'b1;
                                end
                                act        = ACT_PUMP;
                                phase_next = ST_WAIT_PUMP;
                            end
                        end
                        ST_WAIT_PUMP:
                        begin
                            if (item.pump_idle)
                            begin
                                if (cur_valid)
                                begin
                                    cur_next = cur_reg + CUR_W'(1);
                                end
                                phase_next = ST_PICK;
                            end
                        end
                        ST_WAIT_LAST:
                        begin
                            if (item.stepper_idle)
                            begin
                                act        = ACT_PARK;
                                phase_next = ST_WAIT_ACCESS;
                            end
                        end
                        ST_WAIT_ACCESS:
                        begin
                            if (item.stepper_idle && (elapsed_inc >= access_reg))
                            begin
                                elapsed_next = 32'd0;
                                cur_next     = '0;
                                phase_next   = ST_PICK;
                                round_next   = (round_inc == slices_reg) ? 16'd0 : round_inc;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // Configuration writes; an index past the map is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            slices_reg <= 16'd60;
            access_reg <= 32'd60000;
        end
        else if (cfg.we)
        begin
            unique case (cfg.index)
                CFG_ENABLED_MASK: mask_reg   <= cfg.data[MASK_W-1:0];
                CFG_SLICES:       slices_reg <= cfg.data[15:0];
                CFG_ACCESS_MS:    access_reg <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= ST_IDLE;
            cur_reg     <= '0;
            elapsed_reg <= 32'd0;
            round_reg   <= 16'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cur_reg     <= cur_next;
            elapsed_reg <= elapsed_next;
            round_reg   <= round_next;
        end
    end

    // Rate tables have no reset; the user must write an entry before it is read in use, the block does not enforce it.
    always_ff @(posedge clk)
    begin
        if (rate_we)
        begin
            rate_whole_reg[rate_idx] <= item.whole_ticks;
            rate_frac_reg[rate_idx]  <= item.tick_fraction;
        end
    end

    // Residue accumulators: cleared on reset and, for enabled nozzles, on restart.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NOZZLES; i++)
            begin
                residue_reg[i] <= 16'd0;
            end
        end
        else if (res_clear)
        begin
            for (int i = 0; i < NOZZLES; i++)
            begin
                if (on_vec[i])
                begin
                    residue_reg[i] <= 16'd0;
                end
            end
        end
        else if (res_we)
        begin
            residue_reg[cur_idx] <= new_residue;
        end
    end

    assign result.action        = act;
    assign result.target_nozzle = tgt;
    assign result.pump_ticks    = ticks;
    assign result.phase         = phase_code(phase_next);
    assign result.round_index   = round_next;

endmodule

// ===== rtl/core/ndrs_out_stage.sv =====
// Result register of the sequencer: holds one result until the sink takes it.
// Depends on ndrs_pkg and ndrs_out_if.
module ndrs_out_stage
    import ndrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     result,
    output logic        can_load,
    ndrs_out_if.source  results
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // The register frees up when empty or when its result is taken now.
    assign can_load   = !valid_reg || results.ready;
    assign valid_next = load || (valid_reg && !results.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign results.valid         = valid_reg;
    assign results.action        = result_reg.action;
    assign results.target_nozzle = result_reg.target_nozzle;
    assign results.pump_ticks    = result_reg.pump_ticks;
    assign results.phase         = result_reg.phase;
    assign results.round_index   = result_reg.round_index;

endmodule

// ===== rtl/core/nozzle_dose_round_sequencer.sv =====
// Top level of the nozzle dose round sequencer.
// Instantiates ndrs_in_stage, ndrs_core and ndrs_out_stage; depends on ndrs_pkg,
// ndrs_in_if and ndrs_out_if.

// The sequencer takes one request per clock cycle and returns exactly one
// result for each. An accepted request sits in the input register until the
// result register can take it, then moves into it, and its result is held
// there until the sink takes it. All work for a request happens in the
// combinational logic between those two registers: the search for the next
// enabled nozzle, the residue add that forms the dose and the access-period
// compare. Throughput is one request per cycle as long as results are taken.
// While the result side stalls, the block holds at most two requests, one in
// each register. Once both are full, input ready follows result ready in the
// same cycle.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// while no request is in flight. Rates for a nozzle must be written before
// that nozzle is dosed. Residue accumulators start at zero after reset and
// are ready at once.
module nozzle_dose_round_sequencer
    import ndrs_pkg::*;
#(
    parameter int NOZZLES = 18
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ndrs_in_if.sink                items,
    ndrs_out_if.source             results
);

    logic       item_valid;
    item_t      item;
    logic       can_load;
    logic       advance;
    result_t    result;
    cfg_write_t cfg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    // A request moves through the core when the result register can take it.
    assign advance = item_valid && can_load;

    ndrs_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ndrs_core #(
        .NOZZLES (NOZZLES)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .fire   (advance),
        .item   (item),
        .result (result)
    );

    ndrs_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .result   (result),
        .can_load (can_load),
        .results  (results)
    );

`ifndef ASSERT_OFF
    // A move always names an existing nozzle.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.action == ACT_MOVE)
        |-> (6'(results.target_nozzle) < 6'(NOZZLES)))
        else $error("move result names a nozzle out of range");

    // A pump command leaves the sequencer waiting for the pump.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.action == ACT_PUMP)
        |-> (results.phase == PH_WAIT_PUMP))
        else $error("pump result without wait-pump phase");

    // A stop always leaves the sequencer idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.action == ACT_STOP)
        |-> (results.phase == PH_IDLE))
        else $error("stop result without idle phase");

    // When the result side is not stalled the input side never stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.ready |-> items.ready)
        else $error("input stalled while result side is ready");
`endif

endmodule

// ===== test/ndrs_checker.sv =====
// Checker for the nozzle dose round sequencer: watches the register port and both channels.
// Predicts one result per accepted request and compares it field by field.
// Depends on ndrs_pkg, ndrs_in_if and ndrs_out_if.
module ndrs_checker
    import ndrs_pkg::*;
#(
    parameter int NOZZLES = 18
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    ndrs_in_if                     items,
    ndrs_out_if                    results,
    output int                     failures,
    output int                     waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the configuration registers.
    logic [MASK_W-1:0] mask_reg;
    logic [15:0]       slices_reg;
    logic [31:0]       access_reg;

    // Shadow copy of the sequencer state.
    logic [2:0]  seq_ph;
    logic [4:0]  nozzle_at;
    logic [31:0] ms_count;
    logic [15:0] round_no;
    logic [11:0] rate_whole [NOZZLES];
    logic [15:0] rate_frac [NOZZLES];
    logic [15:0] residue [NOZZLES];

    result_t pending_results [$];
    item_t   seen_req;
    result_t seen_res;
    result_t predicted;
    result_t oldest;
    int      fail_count;
    int      j;

    // Work out the result of one request and move the shadow state along.
    task automatic advance_sequencer(input item_t req, output result_t res);
        logic [16:0] sum;
        logic [12:0] ticks;
        int i;
        res = '0;
        case (req.kind)
            KIND_RATE:
            begin
                if (req.rate_nozzle < NOZZLES)
                begin
                    rate_whole[req.rate_nozzle] = req.whole_ticks;
                    rate_frac[req.rate_nozzle] = req.tick_fraction;
                end
            end
            KIND_CTRL:
            begin
                if (req.command == CMD_RESTART)
                begin
                    // Restart keeps the millisecond count and the nozzle pointer.
                    seq_ph = PH_WAIT_MOTOR;
                    round_no = '0;
                    for (i = 0; i < NOZZLES; i++)
                        if (mask_reg[i])
                            residue[i] = '0;
                    res.action = ACT_STOP_RHOME;
                end
                else
                begin
                    seq_ph = PH_IDLE;
                    res.action = ACT_STOP;
                end
            end
            KIND_POLL:
            begin
                case (seq_ph)
                    PH_IDLE: ;
                    PH_WAIT_MOTOR:
                    begin
                        if (req.stepper_idle)
                        begin
                            nozzle_at = '0;
                            seq_ph = req.at_origin ? PH_PICK : PH_HOMING;
                        end
                    end
                    PH_HOMING:
                    begin
                        if (req.homing_done)
                            seq_ph = PH_PICK;
                    end
                    default:
                    begin
                        // Milliseconds only count once the motor is homed.
                        if (req.ms_tick)
                            ms_count = ms_count + 32'd1;
                        case (seq_ph)
                            PH_PICK:
                            begin
                                while (nozzle_at < NOZZLES && !mask_reg[nozzle_at])
                                    nozzle_at = nozzle_at + 5'd1;
                                if (nozzle_at >= NOZZLES)
                                begin
                                    // Round is over: park, moving to the last nozzle first
                                    // unless the motor already sits there.
                                    nozzle_at = 5'(NOZZLES);
                                    if (req.parked_at_last)
                                    begin
                                        res.action = ACT_PARK;
                                        seq_ph = PH_WAIT_ACCESS;
                                    end
                                    else
                                    begin
                                        res.action = ACT_MOVE;
                                        res.target_nozzle = 5'(NOZZLES - 1);
                                        seq_ph = PH_WAIT_LAST;
                                    end
                                end
                                else
                                begin
                                    res.action = ACT_MOVE;
                                    res.target_nozzle = nozzle_at;
                                    seq_ph = PH_WAIT_MOVE;
                                end
                            end
                            PH_WAIT_MOVE:
                            begin
                                if (req.stepper_idle)
                                begin
                                    // Dose is whole ticks plus the residue carry, plus one
                                    // in the last slice when some residue is left.
                                    if (nozzle_at < NOZZLES)
                                    begin
                                        sum = 17'(residue[nozzle_at]) + 17'(rate_frac[nozzle_at]);
                                        residue[nozzle_at] = sum[15:0];
                                        ticks = 13'(rate_whole[nozzle_at]) + 13'(sum[16]);
                                        if (slices_reg != 16'd0 && round_no == slices_reg - 16'd1
                                            && sum[15:0] != 16'd0)
                                            ticks = ticks + 13'd1;
                                        res.pump_ticks = ticks;
                                    end
                                    res.action = ACT_PUMP;
                                    seq_ph = PH_WAIT_PUMP;
                                end
                            end
                            PH_WAIT_PUMP:
                            begin
                                if (req.pump_idle)
                                begin
                                    if (nozzle_at < NOZZLES)
                                        nozzle_at = nozzle_at + 5'd1;
                                    seq_ph = PH_PICK;
                                end
                            end
                            PH_WAIT_LAST:
                            begin
                                if (req.stepper_idle)
                                begin
                                    res.action = ACT_PARK;
                                    seq_ph = PH_WAIT_ACCESS;
                                end
                            end
                            default:
                            begin
                                // Next round starts once parked and the access period is over.
                                if (req.stepper_idle && ms_count >= access_reg)
                                begin
                                    ms_count = '0;
                                    nozzle_at = '0;
                                    seq_ph = PH_PICK;
                                    round_no = round_no + 16'd1;
                                    if (round_no == slices_reg)
                                        round_no = '0;
                                end
                            end
                        endcase
                    end
                endcase
            end
            default: ;
        endcase
        res.phase = seq_ph;
        res.round_index = round_no;
    endtask

    task automatic compare_field(input string name, input int unsigned exp_val,
                                 input int unsigned got_val);
        if (exp_val != got_val)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg = '0;
            slices_reg = 16'd60;
            access_reg = 32'd60000;
            seq_ph = PH_IDLE;
            nozzle_at = '0;
            ms_count = '0;
            round_no = '0;
            for (j = 0; j < NOZZLES; j++)
            begin
                rate_whole[j] = '0;
                rate_frac[j] = '0;
                residue[j] = '0;
            end
            pending_results.delete();
            fail_count = 0;
            failures <= 0;
            waiting <= 0;
        end
        else
        begin
            // Results leave only after their request has passed the input and result registers, so compare first.
            if (results.valid && results.ready)
            begin
                seen_res.action = results.action;
                seen_res.target_nozzle = results.target_nozzle;
                seen_res.pump_ticks = results.pump_ticks;
                seen_res.phase = results.phase;
                seen_res.round_index = results.round_index;
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, seen_res);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    compare_field("action", oldest.action, seen_res.action);
                    compare_field("target_nozzle", oldest.target_nozzle, seen_res.target_nozzle);
                    compare_field("pump_ticks", oldest.pump_ticks, seen_res.pump_ticks);
                    compare_field("phase", oldest.phase, seen_res.phase);
                    compare_field("round_index", oldest.round_index, seen_res.round_index);
                end
            end

            // The user must write registers only with no request in flight; the block itself does not enforce it.
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLED_MASK: mask_reg = cfg_data[MASK_W-1:0];
                    CFG_SLICES:       slices_reg = cfg_data[15:0];
                    CFG_ACCESS_MS:    access_reg = cfg_data;
                    default: ;
                endcase
            end

            if (items.valid && items.ready)
            begin
                seen_req.kind = items.kind;
                seen_req.command = items.command;
                seen_req.stepper_idle = items.stepper_idle;
                seen_req.at_origin = items.at_origin;
                seen_req.homing_done = items.homing_done;
                seen_req.pump_idle = items.pump_idle;
                seen_req.ms_tick = items.ms_tick;
                seen_req.parked_at_last = items.parked_at_last;
                seen_req.rate_nozzle = items.rate_nozzle;
                seen_req.whole_ticks = items.whole_ticks;
                seen_req.tick_fraction = items.tick_fraction;
                advance_sequencer(seen_req, predicted);
                pending_results.push_back(predicted);
            end

            failures <= fail_count;
            waiting <= pending_results.size();
        end
    end

endmodule

// ===== test/nozzle_dose_round_sequencer_test.sv =====
// Testbench top for the nozzle dose round sequencer: clock, reset, requests and verdict.
// Drives directed then random requests through several register settings.
// Depends on ndrs_pkg, both channel interfaces, the block and ndrs_checker.
module nozzle_dose_round_sequencer_test
    import ndrs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NOZZLES = 18;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASES = 12;
    localparam int PHASE_REQUESTS = 160;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES = 10;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   steady;
    logic                   squeeze;
    bit                     gaps_on;
    int                     failures;
    int                     waiting;

    ndrs_in_if  req_ch ();
    ndrs_out_if res_ch ();

    nozzle_dose_round_sequencer #(.NOZZLES(NOZZLES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (req_ch),
        .results   (res_ch)
    );

    ndrs_checker #(.NOZZLES(NOZZLES)) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (req_ch),
        .results   (res_ch),
        .failures  (failures),
        .waiting   (waiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic item_t poll_item(input logic si, input logic ao, input logic hd,
                                        input logic pi, input logic mt, input logic pl);
        item_t it;
        it = '0;
        it.kind = KIND_POLL;
        it.stepper_idle = si;
        it.at_origin = ao;
        it.homing_done = hd;
        it.pump_idle = pi;
        it.ms_tick = mt;
        it.parked_at_last = pl;
        return it;
    endfunction

    function automatic item_t rate_item(input logic [4:0] n, input logic [11:0] whole,
                                        input logic [15:0] frac);
        item_t it;
        it = '0;
        it.kind = KIND_RATE;
        it.rate_nozzle = n;
        it.whole_ticks = whole;
        it.tick_fraction = frac;
        return it;
    endfunction

    function automatic item_t ctrl_item(input logic cmd);
        item_t it;
        it = '0;
        it.kind = KIND_CTRL;
        it.command = cmd;
        return it;
    endfunction

    // Mostly polls biased so rounds make progress; some rate writes and commands.
    function automatic item_t random_request();
        item_t it;
        int pick;
        it.kind = KIND_POLL;
        it.command = 1'($urandom);
        it.stepper_idle = ($urandom_range(0, 99) < 70);
        it.at_origin = ($urandom_range(0, 99) < 50);
        it.homing_done = ($urandom_range(0, 99) < 40);
        it.pump_idle = ($urandom_range(0, 99) < 60);
        it.ms_tick = ($urandom_range(0, 99) < 60);
        it.parked_at_last = ($urandom_range(0, 99) < 30);
        it.rate_nozzle = 5'($urandom);
        it.whole_ticks = 12'($urandom);
        it.tick_fraction = 16'($urandom);
        pick = $urandom_range(0, 199);
        if (pick < 4)
        begin
            it.kind = KIND_CTRL;
            it.command = CMD_RESTART;
        end
        else if (pick < 5)
        begin
            it.kind = KIND_CTRL;
            it.command = CMD_STOP;
        end
        else if (pick < 17)
        begin
            it.kind = KIND_RATE;
            if ($urandom_range(0, 9) == 0)
                it.rate_nozzle = 5'($urandom_range(NOZZLES, 31));
            else
                it.rate_nozzle = 5'($urandom_range(0, NOZZLES - 1));
        end
        else if (pick < 19)
            it.kind = KIND_UNUSED;
        return it;
    endfunction

    task automatic drive_request(input item_t it);
        req_ch.kind <= it.kind;
        req_ch.command <= it.command;
        req_ch.stepper_idle <= it.stepper_idle;
        req_ch.at_origin <= it.at_origin;
        req_ch.homing_done <= it.homing_done;
        req_ch.pump_idle <= it.pump_idle;
        req_ch.ms_tick <= it.ms_tick;
        req_ch.parked_at_last <= it.parked_at_last;
        req_ch.rate_nozzle <= it.rate_nozzle;
        req_ch.whole_ticks <= it.whole_ticks;
        req_ch.tick_fraction <= it.tick_fraction;
    endtask

    // Offer one request, with random idle cycles ahead of it, and wait until taken.
    task automatic push_request(input item_t it);
        while (gaps_on && !steady && $urandom_range(0, 99) < 30)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        drive_request(it);
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [31:0] mask, input logic [31:0] slices,
                                input logic [31:0] access);
        cfg_we <= 1'b1;
        cfg_index <= CFG_ENABLED_MASK;
        cfg_data <= mask;
        @(posedge clk);
        cfg_index <= CFG_SLICES;
        cfg_data <= slices;
        @(posedge clk);
        cfg_index <= CFG_ACCESS_MS;
        cfg_data <= access;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls, one long hold-off on request, none while steady.
    initial
    begin : receiver
        int held;
        bit squeezed;
        squeezed = 1'b0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (squeeze && !squeezed)
            begin
                squeezed = 1'b1;
                res_ch.ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
                res_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
        end
    end

    // Ends the run when nothing moves on either channel for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        int ph;
        int k;
        logic [11:0] whole;
        logic [15:0] frac;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        steady <= 1'b0;
        squeeze <= 1'b0;
        gaps_on = 1'b1;
        req_ch.valid <= 1'b0;
        drive_request('0);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Rates for every nozzle first, so that no dose reads an unwritten rate.
        for (n = 0; n < NOZZLES; n++)
        begin
            whole = (n % 2 == 1) ? 12'hFFF : 12'(n * 100);
            frac = (n % 3 == 0) ? 16'hFFFF : ((n % 3 == 1) ? 16'h0000 : 16'(n * 1000));
            push_request(rate_item(5'(n), whole, frac));
        end
        // Out-of-range nozzle and the unused kind are both ignored.
        push_request(rate_item(5'd31, 12'hFFF, 16'hFFFF));
        push_request(item_t'({KIND_UNUSED, {40{1'b1}}}));
        // Poll while idle, then a round with no enabled nozzle through homing and parking.
        push_request(poll_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        push_request(ctrl_item(CMD_RESTART));
        push_request(poll_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        push_request(poll_item(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        push_request(poll_item(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        push_request(poll_item(1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        push_request(ctrl_item(CMD_STOP));
        settle();

        // Random requests under a series of register settings.
        for (ph = 0; ph < PHASES; ph++)
        begin
            steady <= (ph == 3);
            squeeze <= (ph == 2);
            case (ph)
                0: write_config(32'h0003FFFF, 32'd2, 32'd3);
                1: write_config(32'd0, 32'd1, 32'd0);
                2: write_config($urandom, 32'd0, 32'd1);
                3: write_config(32'd1, 32'h0000FFFF, 32'd2);
                4: write_config(32'hFFFFFFFF, 32'd1, 32'hFFFFFFFF);
                5: write_config($urandom, 32'hFFFF0003, 32'd0);
                default: write_config($urandom, {16'($urandom_range(0, 65535)), 16'(
                                      $urandom_range(0, 4))}, $urandom_range(0, 6));
            endcase
            // Even phases start over from homing; odd ones keep the round counter running.
            if (ph % 2 == 0)
                push_request(ctrl_item(CMD_RESTART));
            for (k = 0; k < PHASE_REQUESTS; k++)
                push_request(random_request());
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0 && waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
